// ----- hdl/mcbp_pkg.sv -----
package mcbp_pkg;

  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_SKIP    = 8'hFF;
  localparam logic [7:0] CHAR_SEND    = 8'h53;
  localparam logic [7:0] CHAR_TERM    = 8'h54;
  localparam logic [7:0] CHAR_NORMAL  = 8'h4E;
  localparam logic [7:0] LETTER_RESET = 8'h7A;

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cmd_letter;
    logic [31:0] cmd_address;
    logic [31:0] cmd_value;
    logic [7:0]  payload_byte;
    logic [31:0] payload_offset;
    logic        last;
    logic        terminal_mode;
  } result_t;

endpackage

// ----- hdl/mcbp_parser.sv -----
module mcbp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output mcbp_pkg::result_t res
);
  import mcbp_pkg::*;

  logic [7:0]  letter_reg;
  logic [31:0] number_reg;
  logic [31:0] address_reg;
  logic        term_flag;
  logic [31:0] payload_left;
  logic [31:0] payload_pos;

  logic [7:0]  letter_reg_next;
  logic [31:0] number_reg_next;
  logic [31:0] address_reg_next;
  logic        term_flag_next;
  logic [31:0] payload_left_next;
  logic [31:0] payload_pos_next;

  logic        is_hex;
  logic [3:0]  hex_val;
  logic        in_payload;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      hex_val = rx_byte[3:0];
    end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
                 (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
      hex_val = rx_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign in_payload = (payload_left != 32'd0);

  always_comb begin
    letter_reg_next   = letter_reg;
    number_reg_next   = number_reg;
    address_reg_next  = address_reg;
    term_flag_next    = term_flag;
    payload_left_next = payload_left;
    payload_pos_next  = payload_pos;
    res_valid         = 1'b0;
    res               = '0;
    if (in_payload) begin
      res_valid           = 1'b1;
      res.kind            = KIND_PAYLOAD;
      res.payload_byte    = rx_byte;
      res.payload_offset  = payload_pos;
      res.last            = (payload_left == 32'd1);
      res.terminal_mode   = term_flag;
      payload_left_next   = payload_left - 32'd1;
      payload_pos_next    = payload_pos + 32'd1;
    end else if (rx_byte == CHAR_SKIP) begin
      res_valid = 1'b0;
    end else if (rx_byte == CHAR_HASH) begin
      if (letter_reg == CHAR_SEND) begin
        payload_left_next = number_reg;
        payload_pos_next  = 32'd0;
      end else if (letter_reg == CHAR_TERM) begin
        term_flag_next = 1'b1;
      end else if (letter_reg == CHAR_NORMAL) begin
        term_flag_next = 1'b0;
      end
      res_valid         = 1'b1;
      res.kind          = KIND_COMMAND;
      res.cmd_letter    = letter_reg;
      res.cmd_address   = address_reg;
      res.cmd_value     = number_reg;
      res.terminal_mode = term_flag_next;
      letter_reg_next   = LETTER_RESET;
      number_reg_next   = 32'd0;
    end else if (is_hex) begin
      number_reg_next = {number_reg[27:0], hex_val};
    end else if (rx_byte == CHAR_COMMA) begin
      address_reg_next = number_reg;
      number_reg_next  = 32'd0;
    end else begin
      letter_reg_next = rx_byte;
      number_reg_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_reg   <= LETTER_RESET;
      number_reg   <= 32'd0;
      address_reg  <= 32'd0;
      term_flag    <= 1'b0;
      payload_left <= 32'd0;
      payload_pos  <= 32'd0;
    end else if (take) begin
      letter_reg   <= letter_reg_next;
      number_reg   <= number_reg_next;
      address_reg  <= address_reg_next;
      term_flag    <= term_flag_next;
      payload_left <= payload_left_next;
      payload_pos  <= payload_pos_next;
    end
  end

endmodule

// ----- hdl/mcbp_outbuf.sv -----
module mcbp_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mcbp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mcbp_pkg::result_t out_data
);
  import mcbp_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_free;

  assign full     = skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- hdl/monitor_command_byte_parser_core.sv -----
// Monitor command byte parser: one received byte is taken per transaction
// while in_stall is low, so bytes may arrive back to back. A command result
// is registered into the output buffer when its '#' byte is taken, and each
// raw byte of an S payload likewise when it is taken, with its offset and a
// last mark on the final byte. Bytes of 0xFF outside a payload and the
// digits, commas and letters of a command give no result. A two-entry
// output register lets input continue while one result waits; in_stall
// rises only when both entries are full.
module monitor_command_byte_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  cmd_letter,
  output logic [31:0] cmd_address,
  output logic [31:0] cmd_value,
  output logic [7:0]  payload_byte,
  output logic [31:0] payload_offset,
  output logic        last,
  output logic        terminal_mode
);
  import mcbp_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    buf_full;

  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  mcbp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mcbp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind           = out_data.kind;
  assign cmd_letter     = out_data.cmd_letter;
  assign cmd_address    = out_data.cmd_address;
  assign cmd_value      = out_data.cmd_value;
  assign payload_byte   = out_data.payload_byte;
  assign payload_offset = out_data.payload_offset;
  assign last           = out_data.last;
  assign terminal_mode  = out_data.terminal_mode;

  // The skid entry can only be occupied behind a waiting output.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // The buffer fills only while the output is held.
  a_stall_after_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("skid entry filled without a held output");

  a_command_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_COMMAND) |-> (payload_offset == 32'd0 && !last &&
                                             payload_byte == 8'd0))
    else $error("command result carries payload fields");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PAYLOAD) |-> (cmd_letter == 8'd0 &&
                                             cmd_address == 32'd0 &&
                                             cmd_value == 32'd0))
    else $error("payload result carries command fields");

endmodule
